FILE: hw/rtl/lidar_frame_sync_crc8_core_macros.svh
// ----------------------------------------------------------------------------
// lidar_frame_sync_crc8_core_macros
// Assertion macros for the LiDAR frame deframer; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef LIDAR_FRAME_SYNC_CRC8_CORE_MACROS_SVH
`define LIDAR_FRAME_SYNC_CRC8_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define LFSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
// Next-cycle implication
`define LFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define LFSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/lfsc_pkg.sv
// ----------------------------------------------------------------------------
// lfsc_pkg
// Shared constants and types of the LiDAR frame deframer.
// ----------------------------------------------------------------------------
package lfsc_pkg;

    localparam int POINTS_PER_FRAME = 12;
    localparam int FRAME_LEN        = 11 + 3 * POINTS_PER_FRAME;
    localparam int CNT_W            = $clog2(FRAME_LEN + 1);
    localparam int PT_W             = 4;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_ADDR_W       = 3;

    localparam logic [7:0] HEADER_RESET = 8'h54;
    localparam logic [7:0] CRC_POLY     = 8'h4D;

    // register indexes (paddr[2] selects)
    localparam logic [0:0] REG_HEADER_BYTE = 1'b0;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CRC,
        FS_CHECK,
        FS_ENQ
    } t_front_state;

    typedef struct packed {
        logic [15:0] range_mm;
        logic [7:0]  inten;
    } t_point;

    typedef struct packed {
        logic [7:0]                        ver;
        logic [15:0]                       spd;
        logic [15:0]                       sa;
        logic [15:0]                       ea;
        logic [15:0]                       ts;
        t_point [POINTS_PER_FRAME-1:0]     points;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    typedef struct packed {
        logic [7:0]      ver;
        logic [15:0]     spd;
        logic [15:0]     sa;
        logic [15:0]     ea;
        logic [15:0]     ts;
        logic [PT_W-1:0] idx;
        logic [15:0]     range_mm;
        logic [7:0]      inten;
        logic            last;
    } t_result;

endpackage

FILE: hw/rtl/lfsc_front.sv
// ----------------------------------------------------------------------------
// lfsc_front
// Byte window, header hunt and iterative CRC-8 check; queues accepted frames.
// ----------------------------------------------------------------------------
module lfsc_front import lfsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_header,
    input  t_queue_stat i_q_stat,
    output logic        o_busy,
    output logic        o_q_push,
    output t_frame      o_frame
);

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    t_front_state     r_state, n_state;
    logic [7:0]       r_win [FRAME_LEN];
    logic [7:0]       n_win [FRAME_LEN];
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_step, n_step;
    logic [7:0]       r_crc, n_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_step <= n_step;
        r_crc  <= n_crc;
    end

    always_comb begin
        n_state  = r_state;
        n_win    = r_win;
        n_count  = r_count;
        n_step   = r_step;
        n_crc    = r_crc;
        o_q_push = 1'b0;
        case (r_state)
            FS_IDLE: begin
                if (i_push) begin
                    for (int i = 0; i < FRAME_LEN - 1; i++) begin
                        n_win[i] = r_win[i+1];
                    end
                    n_win[FRAME_LEN-1] = i_data_byte;
                    if (r_count < CNT_W'(FRAME_LEN)) begin
                        n_count = r_count + 1'b1;
                    end
                    if (n_count == CNT_W'(FRAME_LEN) && r_win[1] == i_header) begin
                        n_state = FS_CRC;
                        n_step  = '0;
                        n_crc   = '0;
                    end
                end
            end
            FS_CRC: begin
                // consume the oldest byte and rotate it to the back
                n_crc = crc8_byte(r_crc, r_win[0]);
                for (int i = 0; i < FRAME_LEN - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[FRAME_LEN-1] = r_win[0];
                n_step = r_step + 1'b1;
                if (r_step == CNT_W'(FRAME_LEN - 2)) begin
                    n_state = FS_CHECK;
                end
            end
            FS_CHECK: begin
                // check byte sits at the front; one more rotation restores the window
                for (int i = 0; i < FRAME_LEN - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[FRAME_LEN-1] = r_win[0];
                n_state = (r_crc == r_win[0]) ? FS_ENQ : FS_IDLE;
            end
            FS_ENQ: begin
                if (!i_q_stat.full) begin
                    o_q_push = 1'b1;
                    n_count  = '0;
                    n_state  = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_frame.ver = r_win[1];
        o_frame.spd = {r_win[3], r_win[2]};
        o_frame.sa  = {r_win[5], r_win[4]};
        o_frame.ea  = {r_win[6 + 3 * POINTS_PER_FRAME + 1], r_win[6 + 3 * POINTS_PER_FRAME]};
        o_frame.ts  = {r_win[8 + 3 * POINTS_PER_FRAME + 1], r_win[8 + 3 * POINTS_PER_FRAME]};
        for (int k = 0; k < POINTS_PER_FRAME; k++) begin
            o_frame.points[k].range_mm = {r_win[6 + 3 * k + 1], r_win[6 + 3 * k]};
            o_frame.points[k].inten    = r_win[6 + 3 * k + 2];
        end
    end

    assign o_busy = (r_state != FS_IDLE);

endmodule

FILE: hw/rtl/lfsc_frame_queue.sv
// ----------------------------------------------------------------------------
// lfsc_frame_queue
// Short FIFO of accepted frame records between the checker and the emitter.
// ----------------------------------------------------------------------------
module lfsc_frame_queue import lfsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  t_frame      i_data,
    input  logic        i_rd,
    output t_frame      o_data,
    output t_queue_stat o_stat
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_frame            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              wr_en, rd_en;

    assign o_stat.full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_fill == '0);
    assign wr_en        = i_wr && !o_stat.full;
    assign rd_en        = i_rd && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_fill = r_fill + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hw/rtl/lfsc_back.sv
// ----------------------------------------------------------------------------
// lfsc_back
// Point emitter: unpacks one frame record into one result per point.
// ----------------------------------------------------------------------------
module lfsc_back import lfsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame      i_q_data,
    input  t_queue_stat i_q_stat,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output t_result     o_result
);

    logic            r_busy, n_busy;
    t_frame          r_frame, n_frame;
    logic [PT_W-1:0] r_pt, n_pt;
    logic            last;

    assign last = (r_pt == PT_W'(POINTS_PER_FRAME - 1));

    always_comb begin
        n_busy  = r_busy;
        n_frame = r_frame;
        n_pt    = r_pt;
        o_q_pop = 1'b0;
        if (r_busy && i_pop) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                // advance: next point moves to the front slot
                for (int i = 0; i < POINTS_PER_FRAME - 1; i++) begin
                    n_frame.points[i] = r_frame.points[i+1];
                end
                n_pt = r_pt + 1'b1;
            end
        end
        if (!n_busy && !i_q_stat.empty) begin
            n_frame = i_q_data;
            n_pt    = '0;
            n_busy  = 1'b1;
            o_q_pop = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        r_pt    <= n_pt;
    end

    assign o_empty           = !r_busy;
    assign o_result.ver      = r_frame.ver;
    assign o_result.spd      = r_frame.spd;
    assign o_result.sa       = r_frame.sa;
    assign o_result.ea       = r_frame.ea;
    assign o_result.ts       = r_frame.ts;
    assign o_result.idx      = r_pt;
    assign o_result.range_mm = r_frame.points[0].range_mm;
    assign o_result.inten    = r_frame.points[0].inten;
    assign o_result.last     = last;

endmodule

FILE: hw/rtl/lidar_frame_sync_crc8_core.sv
// ----------------------------------------------------------------------------
// lidar_frame_sync_crc8_core
// Header-hunting LiDAR frame deframer with CRC-8 check and point emitter.
// ----------------------------------------------------------------------------
// Bytes go in through push/full, one per transfer, into a 47-byte window. A
// byte that completes no candidate frame is taken without raising full. A
// byte that completes a full window starting with the header byte holds full
// high while the CRC-8 unit consumes one window byte per cycle, all but the
// check byte, and while the check byte is compared; an accepted frame then
// keeps full high until it enters a two-frame queue, which waits while that
// queue is full. The emitter pulls frames from the queue and presents 12 point
// results, one per cycle while pop is high, from its output register, so
// bytes keep flowing while results wait. The header byte register sits at
// APB address 0 and resets to 0x54.
`include "lidar_frame_sync_crc8_core_macros.svh"

module lidar_frame_sync_crc8_core import lfsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            i_data_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            o_version_length,
    output logic [15:0]           o_rotation_speed,
    output logic [15:0]           o_sweep_from,
    output logic [15:0]           o_sweep_to,
    output logic [15:0]           o_time_stamp,
    output logic [PT_W-1:0]       o_point_index,
    output logic [15:0]           o_distance_mm,
    output logic [7:0]            o_intensity,
    output logic                  o_last_point,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [7:0]  r_header;
    logic        cfg_wr;
    logic        in_xfer;
    logic        front_busy;
    logic        q_push;
    logic        q_pop;
    t_frame      front_frame;
    t_frame      q_frame;
    t_queue_stat q_stat;
    t_result     result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2:2] == REG_HEADER_BYTE) ? {{(CFG_DATA_W - 8){1'b0}}, r_header}
                                                    : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
        end else if (cfg_wr && paddr[2:2] == REG_HEADER_BYTE) begin
            r_header <= pwdata[7:0];
        end
    end

    assign full    = front_busy;
    assign in_xfer = push && !full;

    lfsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_xfer),
        .i_data_byte (i_data_byte),
        .i_header    (r_header),
        .i_q_stat    (q_stat),
        .o_busy      (front_busy),
        .o_q_push    (q_push),
        .o_frame     (front_frame)
    );

    lfsc_frame_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_push),
        .i_data  (front_frame),
        .i_rd    (q_pop),
        .o_data  (q_frame),
        .o_stat  (q_stat)
    );

    lfsc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_data (q_frame),
        .i_q_stat (q_stat),
        .o_q_pop  (q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (result)
    );

    assign o_version_length = result.ver;
    assign o_rotation_speed = result.spd;
    assign o_sweep_from     = result.sa;
    assign o_sweep_to       = result.ea;
    assign o_time_stamp     = result.ts;
    assign o_point_index    = result.idx;
    assign o_distance_mm    = result.range_mm;
    assign o_intensity      = result.inten;
    assign o_last_point     = result.last;

    `LFSC_ASSERT_IMPLY(a_q_no_overflow, i_clk, i_rst_n, q_push, !q_stat.full)
    `LFSC_ASSERT_IMPLY(a_last_index, i_clk, i_rst_n, !empty && o_last_point, o_point_index == PT_W'(POINTS_PER_FRAME - 1))
    `LFSC_ASSERT_NEXT(a_frame_continues, i_clk, i_rst_n, pop && !empty && !o_last_point, !empty)
    `LFSC_ASSERT_NEXT(a_emitter_loads, i_clk, i_rst_n, empty && !q_stat.empty, !empty)

endmodule

FILE: verif/tb_lidar_frame_sync_crc8_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_frame_sync_crc8_core
// Self-checking testbench for the header-hunting LiDAR frame deframer.
// ----------------------------------------------------------------------------
// Bytes are streamed into the deframer through its push/full side while an
// in-bench copy of the window, the accept counter and the CRC-8 works out
// which frames must be accepted. Every point result popped from the block is
// compared field by field against the oldest predicted point. The header
// register is exercised over the APB port between phases. The stream covers
// the start-up fill, overlap with an accepted frame, extreme header and data
// values under a long result stall, a CRC mismatch, and a closing random mix
// of good, corrupted and truncated frames and false headers without idling.
// ----------------------------------------------------------------------------
module tb_lidar_frame_sync_crc8_core;
    import lfsc_pkg::*;

    localparam logic [7:0] POLY         = 8'h4D;
    localparam int         REG_UNMAPPED = 1;
    localparam int         TAIL_CYCLES  = 2 * FRAME_LEN;
    localparam int         HOLD_CYCLES  = 1000;
    localparam int         EA_POS       = 6 + 3 * POINTS_PER_FRAME;
    localparam int         TS_POS       = 8 + 3 * POINTS_PER_FRAME;

    typedef logic [7:0] t_frame_bytes [FRAME_LEN];

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    logic [7:0]            i_data_byte = 8'h00;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic [7:0]            o_version_length;
    logic [15:0]           o_rotation_speed;
    logic [15:0]           o_sweep_from;
    logic [15:0]           o_sweep_to;
    logic [15:0]           o_time_stamp;
    logic [PT_W-1:0]       o_point_index;
    logic [15:0]           o_distance_mm;
    logic [7:0]            o_intensity;
    logic                  o_last_point;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [CFG_DATA_W-1:0] pwdata      = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state
    logic [7:0]  win [FRAME_LEN];
    int unsigned since_accept = 0;
    logic [7:0]  hdr_model    = HEADER_RESET;
    t_result     point_q [$];

    logic idle_on     = 1'b1;
    int   hold_req    = 0;
    int   hold_ack    = 0;
    int   hold_left   = 0;
    int   pop_gap     = 0;
    int   errors      = 0;
    int   bytes_sent  = 0;
    int   frames_seen = 0;
    int   points_seen = 0;

    lidar_frame_sync_crc8_core dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] crc8_of(input t_frame_bytes f);
        logic [7:0] crc;
        crc = 8'h00;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            crc ^= f[i];
            for (int b = 0; b < 8; b++)
                crc = crc[7] ? ((crc << 1) ^ POLY) : (crc << 1);
        end
        return crc;
    endfunction

    // Shift one byte into the window and queue the points of an accepted frame.
    function automatic void absorb_byte(input logic [7:0] b);
        t_result r;
        for (int i = 0; i < FRAME_LEN - 1; i++)
            win[i] = win[i + 1];
        win[FRAME_LEN - 1] = b;
        if (since_accept < FRAME_LEN)
            since_accept++;
        if (since_accept == FRAME_LEN && win[0] == hdr_model &&
            crc8_of(win) == win[FRAME_LEN - 1]) begin
            since_accept = 0;
            frames_seen++;
            for (int k = 0; k < POINTS_PER_FRAME; k++) begin
                r.ver      = win[1];
                r.spd      = {win[3], win[2]};
                r.sa       = {win[5], win[4]};
                r.ea       = {win[EA_POS + 1], win[EA_POS]};
                r.ts       = {win[TS_POS + 1], win[TS_POS]};
                r.idx      = PT_W'(k);
                r.range_mm = {win[7 + 3 * k], win[6 + 3 * k]};
                r.inten    = win[8 + 3 * k];
                r.last     = (k == POINTS_PER_FRAME - 1);
                point_q.push_back(r);
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic void check_point();
        t_result e;
        if (point_q.size() == 0) begin
            $error("point result with none pending: point_index %0d distance_mm 0x%0h",
                   o_point_index, o_distance_mm);
            errors++;
            return;
        end
        e = point_q.pop_front();
        points_seen++;
        check_field("version_length", e.ver, o_version_length);
        check_field("rotation_speed", e.spd, o_rotation_speed);
        check_field("sweep_from", e.sa, o_sweep_from);
        check_field("sweep_to", e.ea, o_sweep_to);
        check_field("time_stamp", e.ts, o_time_stamp);
        check_field("point_index", e.idx, o_point_index);
        check_field("distance_mm", e.range_mm, o_distance_mm);
        check_field("intensity", e.inten, o_intensity);
        check_field("last_point", e.last, o_last_point);
    endfunction

    // Point sink: check each transfer, then pick pop for the next cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                check_point();
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                pop_gap = $urandom_range(0, 4);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        absorb_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_frame_bytes f, input int count);
        for (int i = 0; i < count; i++)
            send_byte(f[i]);
    endtask

    function automatic void make_frame(output t_frame_bytes f, input logic [7:0] hdr);
        f[0] = hdr;
        for (int i = 1; i < FRAME_LEN - 1; i++)
            f[i] = 8'($urandom);
        f[FRAME_LEN - 1] = crc8_of(f);
    endfunction

    // Drain the results, then let a candidate still under CRC run out.
    task automatic wait_quiet();
        push <= 1'b0;
        while (point_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_access(input int idx, input logic wr, input logic [31:0] val,
                              output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (wr && idx == REG_HEADER_BYTE)
            hdr_model = val[7:0];
        // hold the bus idle between accesses
        @(posedge i_clk);
    endtask

    task automatic set_header(input logic [7:0] hdr);
        logic [31:0] rd;
        cfg_access(REG_HEADER_BYTE, 1'b1, {24'h0, hdr}, rd);
    endtask

    task automatic check_header_readback();
        logic [31:0] rd;
        cfg_access(REG_HEADER_BYTE, 1'b0, '0, rd);
        check_field("header_byte", hdr_model, rd[7:0]);
    endtask

    task automatic test_register_access();
        logic [31:0] rd;
        check_header_readback();
        // a write past the last register must leave the header alone
        cfg_access(REG_UNMAPPED, 1'b1, 32'hFFFF_FF00, rd);
        check_header_readback();
    endtask

    task automatic test_window_fill();
        // zero header against a zeroed window: only a full window may match
        set_header(8'h00);
        for (int i = 0; i < FRAME_LEN; i++)
            send_byte(8'h00);
        // every window is valid here, but overlaps the frame just taken
        for (int i = 0; i < 2; i++)
            send_byte(8'h00);
        wait_quiet();
    endtask

    task automatic test_stall_with_extremes();
        t_frame_bytes f;
        set_header(8'hFF);
        check_header_readback();
        // stall the sink long enough for the frame queue and the checker to fill
        hold_req <= hold_req + 1;
        foreach (f[i]) f[i] = 8'hFF;
        f[FRAME_LEN - 1] = crc8_of(f);
        send_frame(f, FRAME_LEN);
        foreach (f[i]) f[i] = 8'h00;
        f[0] = 8'hFF;
        f[FRAME_LEN - 1] = crc8_of(f);
        send_frame(f, FRAME_LEN);
        for (int n = 0; n < 2; n++) begin
            make_frame(f, hdr_model);
            send_frame(f, FRAME_LEN);
        end
        // keep offering bytes while the input is stalled
        for (int i = 0; i < 3; i++)
            send_byte(8'h00);
        wait_quiet();
    endtask

    task automatic test_crc_mismatch();
        t_frame_bytes f;
        set_header(HEADER_RESET);
        check_header_readback();
        make_frame(f, HEADER_RESET);
        f[FRAME_LEN - 1] ^= 8'h01;
        send_frame(f, FRAME_LEN);
        wait_quiet();
    endtask

    task automatic test_random_stream(input int n_bytes);
        t_frame_bytes f;
        int           start_bytes;
        int           pick;
        int           pos;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < n_bytes) begin
            pick = $urandom_range(0, 99);
            make_frame(f, hdr_model);
            if (pick < 65) begin
                send_frame(f, FRAME_LEN);
            end else if (pick < 78) begin
                pos = $urandom_range(0, FRAME_LEN - 1);
                f[pos] ^= 8'(1 << $urandom_range(0, 7));
                send_frame(f, FRAME_LEN);
            end else if (pick < 88) begin
                send_frame(f, $urandom_range(1, FRAME_LEN - 1));
            end else begin
                repeat ($urandom_range(1, 16))
                    send_byte($urandom_range(0, 3) == 0 ? hdr_model : 8'($urandom));
            end
        end
        wait_quiet();
    endtask

    initial begin
        foreach (win[i]) win[i] = 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_window_fill();
        test_stall_with_extremes();
        test_crc_mismatch();
        set_header(8'($urandom));
        check_header_readback();
        idle_on <= 1'b0;
        test_random_stream(40);

        $display("summary: %0d bytes streamed, %0d frames accepted, %0d points checked",
                 bytes_sent, frames_seen, points_seen);
        $display("summary: header extremes, overlap, bad CRC, truncation and long stall seen");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
